### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent checks on clk_i, disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a condition at every edge
`define BAL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// check that a condition implies another in the next cycle
`define BAL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/bal_pkg.sv
// ----------------------------------------------------------------------------
// Bounded array list package
// Sizes, codes and the control word that drives the row of storage cells.
// ----------------------------------------------------------------------------
package bal_pkg;

  localparam int unsigned DEPTH     = 64;
  localparam int unsigned ELEM_W    = 32;
  localparam int unsigned IDX_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1);
  localparam int unsigned ACT_W     = 2;
  localparam int unsigned STAT_W    = 2;
  localparam int unsigned CAP_W     = 7;
  localparam int unsigned IN_IDX_W  = 6;
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);

  typedef enum logic [ACT_W-1:0] {
    ACT_ADD    = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_GET    = 2'd2,
    ACT_CLEAR  = 2'd3
  } bal_action_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } bal_status_e;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2,
    OP_CLEAR  = 2'd3
  } bal_op_e;

  typedef struct packed {
    bal_op_e           op;
    logic [IDX_W-1:0]  pos;
    logic [IDX_W-1:0]  rd_pos;
    logic [ELEM_W-1:0] data;
  } bal_ctrl_t;

endpackage

### rtl/core/bal_if.sv
// ----------------------------------------------------------------------------
// Bounded array list channels
// Request, result and capacity write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface bal_in_if;
  logic                              valid;
  logic                              ready;
  logic [bal_pkg::ACT_W-1:0]         action;
  logic [bal_pkg::IN_IDX_W-1:0]      index;
  logic                              from_end;
  logic [bal_pkg::ELEM_W-1:0]        element_data;

  modport source (output valid, action, index, from_end, element_data, input ready);
  modport sink (input valid, action, index, from_end, element_data, output ready);
endinterface

interface bal_out_if;
  logic                              valid;
  logic                              ready;
  logic [bal_pkg::STAT_W-1:0]        status;
  logic [bal_pkg::ELEM_W-1:0]        read_data;
  logic                              read_valid;
  logic [bal_pkg::CNT_W-1:0]         count;
  logic                              is_full;
  logic                              is_empty;

  modport source (output valid, status, read_data, read_valid, count, is_full, is_empty,
                  input ready);
  modport sink (input valid, status, read_data, read_valid, count, is_full, is_empty,
                output ready);
endinterface

interface bal_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [bal_pkg::CAP_W-1:0]         data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

### rtl/core/bal_cell.sv
// ----------------------------------------------------------------------------
// Bounded array list cell
// One list slot: loads from its lower or upper neighbor on insert or delete, or the new element at the insert position.
// ----------------------------------------------------------------------------
module bal_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bal_pkg::bal_ctrl_t            ctrl_i,
  input  logic [bal_pkg::IDX_W-1:0]     idx_i,
  input  logic [bal_pkg::ELEM_W-1:0]    lo_data_i,
  input  logic                          lo_valid_i,
  input  logic [bal_pkg::ELEM_W-1:0]    hi_data_i,
  input  logic                          hi_valid_i,
  output logic [bal_pkg::ELEM_W-1:0]    data_o,
  output logic                          valid_o,
  output logic [bal_pkg::ELEM_W-1:0]    rd_data_o,
  output logic                          rd_valid_o
);

  logic [bal_pkg::ELEM_W-1:0] data_q, data_d;
  logic                       valid_q, valid_d;
  logic                       hit;

  always_comb begin
    data_d  = data_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      bal_pkg::OP_INSERT: begin
        if (idx_i > ctrl_i.pos) begin
          data_d  = lo_data_i;
          valid_d = lo_valid_i;
        end else if (idx_i == ctrl_i.pos) begin
          data_d  = ctrl_i.data;
          valid_d = 1'b1;
        end
      end
      bal_pkg::OP_DELETE: begin
        if (idx_i >= ctrl_i.pos) begin
          data_d  = hi_data_i;
          valid_d = hi_valid_i;
        end
      end
      bal_pkg::OP_CLEAR: begin
        valid_d = 1'b0;
      end
      bal_pkg::OP_HOLD: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign hit        = (idx_i == ctrl_i.rd_pos);
  assign data_o     = data_q;
  assign valid_o    = valid_q;
  assign rd_data_o  = hit ? data_q : '0;
  assign rd_valid_o = hit & valid_q;

endmodule

### rtl/core/bal_chain.sv
// ----------------------------------------------------------------------------
// Bounded array list cell row
// Links the cells to their neighbors and merges the selected read slot.
// ----------------------------------------------------------------------------
module bal_chain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bal_pkg::bal_ctrl_t            ctrl_i,
  output logic [bal_pkg::DEPTH-1:0]     valid_o,
  output logic [bal_pkg::ELEM_W-1:0]    rd_data_o,
  output logic                          rd_valid_o
);

  logic [bal_pkg::ELEM_W-1:0] cell_data [bal_pkg::DEPTH];
  logic [bal_pkg::ELEM_W-1:0] cell_rd   [bal_pkg::DEPTH];
  logic [bal_pkg::DEPTH-1:0]  cell_rd_valid;

  for (genvar g = 0; g < bal_pkg::DEPTH; g++) begin : g_cell
    logic [bal_pkg::ELEM_W-1:0] lo_data, hi_data;
    logic                       lo_valid, hi_valid;

    if (g == 0) begin : g_bottom
      assign lo_data  = '0;
      assign lo_valid = 1'b0;
    end else begin : g_lower
      assign lo_data  = cell_data[g-1];
      assign lo_valid = valid_o[g-1];
    end

    if (g == bal_pkg::DEPTH - 1) begin : g_top
      assign hi_data  = '0;
      assign hi_valid = 1'b0;
    end else begin : g_upper
      assign hi_data  = cell_data[g+1];
      assign hi_valid = valid_o[g+1];
    end

    bal_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .idx_i      (bal_pkg::IDX_W'(g)),
      .lo_data_i  (lo_data),
      .lo_valid_i (lo_valid),
      .hi_data_i  (hi_data),
      .hi_valid_i (hi_valid),
      .data_o     (cell_data[g]),
      .valid_o    (valid_o[g]),
      .rd_data_o  (cell_rd[g]),
      .rd_valid_o (cell_rd_valid[g])
    );
  end

  always_comb begin
    rd_data_o = '0;
    for (int i = 0; i < bal_pkg::DEPTH; i++) begin
      rd_data_o = rd_data_o | cell_rd[i];
    end
  end

  assign rd_valid_o = |cell_rd_valid;

endmodule

### rtl/core/bounded_array_list_core.sv
// ----------------------------------------------------------------------------
// Bounded array list core
// Ordered list with insert, delete, read and clear over a row of shift cells.
// ----------------------------------------------------------------------------
// Usage:
//   in_i   request transfer: action, index, from_end, element_data.
//   out_o  one result transfer per request: status, read_data, read_valid,
//          count, is_full, is_empty.
//   cfg_i  capacity write, always ready; write only while no request is open.
// Result: registered, valid in the cycle after the request transfer.
// Throughput: one request per cycle while out_o.ready is high. The cells at
//   and above the position all load in the same cycle, so an insert or
//   delete at any position needs no serial shift; a read selects one cell of the row.
// Stall: the result register holds while out_o.ready is low; a new request
//   is taken in the cycle that the held result is taken.
// Reset: the list is empty, all slots are marked free, capacity is 64 and
//   no result is pending. Slot payloads are not cleared.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bounded_array_list_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  bal_in_if.sink     in_i,
  bal_out_if.source  out_o,
  bal_cfg_if.sink    cfg_i
);

  logic [bal_pkg::CAP_W-1:0]   capacity_q;
  logic [bal_pkg::CNT_W-1:0]   fill_q, fill_d;
  logic [bal_pkg::CNT_W-1:0]   cap, fill_m1, idx_ext, add_pos, rm_pos, get_pos;
  logic                        in_acc;
  logic                        rd_ok;
  bal_pkg::bal_op_e            op;
  bal_pkg::bal_status_e        status;
  bal_pkg::bal_ctrl_t          ctrl;
  logic [bal_pkg::DEPTH-1:0]   valid_vec;
  logic [bal_pkg::DEPTH-1:0]   fill_mask;
  logic [bal_pkg::ELEM_W-1:0]  chain_rd_data;
  logic                        chain_rd_valid;

  logic                        out_valid_q;
  bal_pkg::bal_status_e        out_status_q;
  logic [bal_pkg::ELEM_W-1:0]  out_rdata_q;
  logic                        out_rvalid_q;
  logic [bal_pkg::CNT_W-1:0]   out_count_q;
  logic                        out_full_q;
  logic                        out_empty_q;

  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_acc      = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;

  assign cap     = (bal_pkg::CNT_W'(capacity_q) > bal_pkg::CNT_W'(bal_pkg::DEPTH)) ?
                   bal_pkg::CNT_W'(bal_pkg::DEPTH) : bal_pkg::CNT_W'(capacity_q);
  assign fill_m1 = fill_q - bal_pkg::CNT_W'(1);
  assign idx_ext = bal_pkg::CNT_W'(in_i.index);
  assign add_pos = in_i.from_end ? fill_q : idx_ext;
  assign rm_pos  = in_i.from_end ? fill_m1 : idx_ext;
  assign get_pos = in_i.from_end ? fill_m1 : idx_ext;

  // decode request
  always_comb begin
    status = bal_pkg::ST_OK;
    op     = bal_pkg::OP_HOLD;
    fill_d = fill_q;
    rd_ok  = 1'b0;
    unique case (bal_pkg::bal_action_e'(in_i.action))
      bal_pkg::ACT_ADD: begin
        if (add_pos > fill_q || add_pos >= cap) begin
          status = bal_pkg::ST_INVALID;
        end else if (fill_q >= cap) begin
          status = bal_pkg::ST_FULL;
        end else begin
          op     = bal_pkg::OP_INSERT;
          fill_d = fill_q + bal_pkg::CNT_W'(1);
        end
      end
      bal_pkg::ACT_REMOVE: begin
        if (fill_q == '0 || rm_pos >= fill_q || rm_pos >= cap) begin
          status = (fill_q == '0) ? bal_pkg::ST_EMPTY : bal_pkg::ST_INVALID;
        end else begin
          op     = bal_pkg::OP_DELETE;
          fill_d = fill_m1;
        end
      end
      bal_pkg::ACT_GET: begin
        if (fill_q == '0 || get_pos >= fill_q) begin
          status = bal_pkg::ST_INVALID;
        end else begin
          rd_ok = 1'b1;
        end
      end
      bal_pkg::ACT_CLEAR: begin
        op     = bal_pkg::OP_CLEAR;
        fill_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    ctrl.op     = in_acc ? op : bal_pkg::OP_HOLD;
    ctrl.pos    = (op == bal_pkg::OP_DELETE) ? rm_pos[bal_pkg::IDX_W-1:0]
                                             : add_pos[bal_pkg::IDX_W-1:0];
    ctrl.rd_pos = get_pos[bal_pkg::IDX_W-1:0];
    ctrl.data   = in_i.element_data;
  end

  bal_chain u_chain (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .valid_o    (valid_vec),
    .rd_data_o  (chain_rd_data),
    .rd_valid_o (chain_rd_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= bal_pkg::CAP_RESET;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        capacity_q <= cfg_i.data;
      end
      if (in_acc) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      out_status_q <= status;
      out_rdata_q  <= rd_ok ? chain_rd_data : '0;
      out_rvalid_q <= rd_ok & chain_rd_valid;
      out_count_q  <= fill_d;
      out_full_q   <= (fill_d >= cap);
      out_empty_q  <= (fill_d == '0);
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = out_status_q;
  assign out_o.read_data  = out_rdata_q;
  assign out_o.read_valid = out_rvalid_q;
  assign out_o.count      = out_count_q;
  assign out_o.is_full    = out_full_q;
  assign out_o.is_empty   = out_empty_q;

  always_comb begin
    for (int i = 0; i < bal_pkg::DEPTH; i++) begin
      fill_mask[i] = (bal_pkg::CNT_W'(i) < fill_q);
    end
  end

  `BAL_ASSERT(a_fill_bound, fill_q <= bal_pkg::CNT_W'(bal_pkg::DEPTH), "fill count above depth")
  `BAL_ASSERT(a_valid_match, valid_vec == fill_mask, "slot valid bits disagree with fill count")
  `BAL_ASSERT_NEXT(a_count_track, in_acc, out_valid_q && out_o.count == fill_q, "result count mismatch")

endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded array list core testbench
// Drives list requests and capacity writes on valid/ready channels with random
// gaps and stalls. Every result is checked field by field against a predicted
// copy of the list, kept in step at each accepted request transfer.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD   = 150;

  typedef struct packed {
    bal_pkg::bal_action_e       act;
    logic [5:0]                 idx;
    logic                       from_end;
    logic [bal_pkg::ELEM_W-1:0] data;
  } list_op_t;

  typedef struct packed {
    bal_pkg::bal_status_e       status;
    logic [bal_pkg::ELEM_W-1:0] rdata;
    logic                       rvalid;
    logic [6:0]                 count;
    logic                       full;
    logic                       empty;
  } list_reply_t;

  typedef struct {
    logic [bal_pkg::ELEM_W-1:0] mem [bal_pkg::DEPTH];
    bit                         used [bal_pkg::DEPTH];
    int                         cnt;
    logic [6:0]                 cap;
  } list_t;

  logic clk_i;
  logic rst_ni;

  bal_in_if  req_bus ();
  bal_out_if rsp_bus ();
  bal_cfg_if cap_bus ();

  bounded_array_list_core uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (req_bus),
    .out_o  (rsp_bus),
    .cfg_i  (cap_bus)
  );

  list_op_t    op_q [$];
  list_reply_t reply_q [$];
  list_t       chk_list;
  list_t       gen_list;

  bit req_fire, rsp_fire, cap_fire;
  bit sender_idle, receiver_idle;
  int send_gap, stall_cnt, hold_cnt;
  int hold_asked, hold_done;
  int cycle_cnt, mism_cnt, req_cnt, push_cnt, cap_writes;
  int status_seen [4];

  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    else if (roll < 90) return $urandom_range(1, 3);
    else return $urandom_range(8, 30);
  endfunction

  function automatic list_reply_t list_apply(inout list_t s, input list_op_t op);
    list_reply_t rsp;
    int lim;
    int pos;
    lim = (s.cap > bal_pkg::DEPTH) ? bal_pkg::DEPTH : int'(s.cap);
    rsp = '0;
    rsp.status = bal_pkg::ST_OK;
    case (op.act)
      bal_pkg::ACT_ADD: begin
        pos = op.from_end ? s.cnt : int'(op.idx);
        if (pos > s.cnt || pos >= lim) begin
          rsp.status = bal_pkg::ST_INVALID;
        end else if (s.cnt >= lim) begin
          rsp.status = bal_pkg::ST_FULL;
        end else begin
          for (int i = s.cnt; i > pos; i--) begin
            s.mem[i]  = s.mem[i-1];
            s.used[i] = s.used[i-1];
          end
          s.mem[pos]  = op.data;
          s.used[pos] = 1'b1;
          s.cnt++;
        end
      end
      bal_pkg::ACT_REMOVE: begin
        pos = op.from_end ? ((s.cnt == 0) ? 0 : s.cnt - 1) : int'(op.idx);
        if (pos >= s.cnt || pos >= lim) begin
          rsp.status = (s.cnt == 0) ? bal_pkg::ST_EMPTY : bal_pkg::ST_INVALID;
        end else begin
          for (int i = pos; i + 1 < s.cnt; i++) begin
            s.mem[i]  = s.mem[i+1];
            s.used[i] = s.used[i+1];
          end
          s.used[s.cnt-1] = 1'b0;
          s.cnt--;
        end
      end
      bal_pkg::ACT_GET: begin
        pos = op.from_end ? s.cnt - 1 : int'(op.idx);
        if (pos < 0 || pos >= s.cnt) begin
          rsp.status = bal_pkg::ST_INVALID;
        end else begin
          rsp.rdata  = s.mem[pos];
          rsp.rvalid = s.used[pos];
        end
      end
      default: begin
        for (int i = 0; i < bal_pkg::DEPTH; i++) s.used[i] = 1'b0;
        s.cnt = 0;
      end
    endcase
    rsp.count = 7'(s.cnt);
    rsp.full  = (s.cnt >= lim);
    rsp.empty = (s.cnt == 0);
    return rsp;
  endfunction

  function automatic void check_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, what, want, got);
      mism_cnt++;
    end
  endfunction

  always @(posedge clk_i) begin : monitor
    list_reply_t want;
    list_op_t    acc;
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("end of test: mismatches");
      $finish;
    end else if (!rst_ni) begin
      req_fire = 1'b0;
      rsp_fire = 1'b0;
      cap_fire = 1'b0;
      for (int i = 0; i < bal_pkg::DEPTH; i++) begin
        chk_list.mem[i]  = '0;
        chk_list.used[i] = 1'b0;
      end
      chk_list.cnt = 0;
      chk_list.cap = bal_pkg::CAP_RESET;
    end else begin
      req_fire = req_bus.valid && req_bus.ready;
      rsp_fire = rsp_bus.valid && rsp_bus.ready;
      cap_fire = cap_bus.valid && cap_bus.ready;
      if (cap_fire) chk_list.cap = cap_bus.data;
      if (rsp_fire) begin
        if (reply_q.size() == 0) begin
          $display("%0t ns: result transfer with nothing expected, status %0d count %0d",
                   $time, rsp_bus.status, rsp_bus.count);
          mism_cnt++;
        end else begin
          want = reply_q.pop_front();
          check_field("status", 32'(want.status), 32'(rsp_bus.status));
          check_field("read_data", want.rdata, rsp_bus.read_data);
          check_field("read_valid", 32'(want.rvalid), 32'(rsp_bus.read_valid));
          check_field("count", 32'(want.count), 32'(rsp_bus.count));
          check_field("is_full", 32'(want.full), 32'(rsp_bus.is_full));
          check_field("is_empty", 32'(want.empty), 32'(rsp_bus.is_empty));
          status_seen[want.status]++;
        end
      end
      if (req_fire) begin
        acc.act      = bal_pkg::bal_action_e'(req_bus.action);
        acc.idx      = req_bus.index;
        acc.from_end = req_bus.from_end;
        acc.data     = req_bus.element_data;
        reply_q.push_back(list_apply(chk_list, acc));
        req_cnt++;
      end
    end
  end

  always @(negedge clk_i) begin : driver
    list_op_t nxt;
    if (!req_bus.valid || req_fire) begin
      if (send_gap > 0) begin
        req_bus.valid <= 1'b0;
        send_gap--;
      end else if (op_q.size() > 0) begin
        nxt = op_q.pop_front();
        req_bus.valid        <= 1'b1;
        req_bus.action       <= nxt.act;
        req_bus.index        <= nxt.idx;
        req_bus.from_end     <= nxt.from_end;
        req_bus.element_data <= nxt.data;
        send_gap = sender_idle ? pick_gap() : 0;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin : receiver
    if (hold_done != hold_asked) begin
      hold_cnt  = LONG_HOLD;
      hold_done = hold_asked;
    end
    if (hold_cnt > 0) begin
      rsp_bus.ready <= 1'b0;
      hold_cnt--;
    end else if (stall_cnt > 0) begin
      rsp_bus.ready <= 1'b0;
      stall_cnt--;
    end else if (receiver_idle && $urandom_range(0, 99) < 25) begin
      rsp_bus.ready <= 1'b0;
      stall_cnt = pick_gap();
    end else begin
      rsp_bus.ready <= 1'b1;
    end
  end

  task automatic push_op(input bal_pkg::bal_action_e act, input int idx, input bit fe,
                         input logic [31:0] data);
    list_op_t op;
    op.act      = act;
    op.idx      = 6'(idx);
    op.from_end = fe;
    op.data     = data;
    op_q.push_back(op);
    push_cnt++;
  endtask

  task automatic push_random(input int add_pct, input int rm_pct, input int get_pct);
    list_op_t    op;
    int          roll;
    int          top;
    roll = $urandom_range(0, 99);
    if (roll < add_pct) op.act = bal_pkg::ACT_ADD;
    else if (roll < add_pct + rm_pct) op.act = bal_pkg::ACT_REMOVE;
    else if (roll < add_pct + rm_pct + get_pct) op.act = bal_pkg::ACT_GET;
    else op.act = bal_pkg::ACT_CLEAR;
    op.from_end = ($urandom_range(0, 3) == 0);
    top = (op.act == bal_pkg::ACT_ADD) ? gen_list.cnt : gen_list.cnt - 1;
    if (top < 0) top = 0;
    if (top > 63) top = 63;
    op.idx = ($urandom_range(0, 99) < 75) ? 6'($urandom_range(0, top)) : 6'($urandom);
    case ($urandom_range(0, 9))
      0: op.data = '0;
      1: op.data = '1;
      default: op.data = $urandom;
    endcase
    void'(list_apply(gen_list, op));
    op_q.push_back(op);
    push_cnt++;
  endtask

  task automatic settle();
    @(negedge clk_i);
    while (req_cnt != push_cnt || reply_q.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic set_capacity(input logic [6:0] cap);
    @(negedge clk_i);
    cap_bus.valid <= 1'b1;
    cap_bus.data  <= cap;
    do @(negedge clk_i); while (!cap_fire);
    cap_bus.valid <= 1'b0;
    cap_writes++;
  endtask

  task automatic run_phase(input logic [6:0] cap, input int n, input int add_pct,
                           input int rm_pct, input int get_pct, input bit idle,
                           input bit hold);
    set_capacity(cap);
    gen_list      = chk_list;
    sender_idle   = idle;
    receiver_idle = idle;
    repeat (n) push_random(add_pct, rm_pct, get_pct);
    if (hold) hold_asked++;
    settle();
  endtask

  initial begin : stimulus
    logic [6:0] mid_cap;
    rst_ni               = 1'b0;
    req_bus.valid        = 1'b0;
    req_bus.action       = bal_pkg::ACT_ADD;
    req_bus.index        = '0;
    req_bus.from_end     = 1'b0;
    req_bus.element_data = '0;
    rsp_bus.ready        = 1'b0;
    cap_bus.valid        = 1'b0;
    cap_bus.data         = '0;
    sender_idle          = 1'b1;
    receiver_idle        = 1'b1;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    push_op(bal_pkg::ACT_GET, 0, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_REMOVE, 0, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_REMOVE, 0, 1'b1, 32'h0);
    push_op(bal_pkg::ACT_GET, 0, 1'b1, 32'h0);
    push_op(bal_pkg::ACT_ADD, 1, 1'b0, 32'h1111_1111);
    push_op(bal_pkg::ACT_ADD, 0, 1'b1, 32'hFFFF_FFFF);
    push_op(bal_pkg::ACT_ADD, 0, 1'b0, 32'h0000_0000);
    push_op(bal_pkg::ACT_ADD, 1, 1'b0, 32'hA5A5_A5A5);
    push_op(bal_pkg::ACT_GET, 0, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_GET, 1, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_GET, 2, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_GET, 63, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_GET, 0, 1'b1, 32'h0);
    push_op(bal_pkg::ACT_REMOVE, 1, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_REMOVE, 0, 1'b1, 32'h0);
    push_op(bal_pkg::ACT_REMOVE, 63, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_ADD, 63, 1'b0, 32'h5A5A_5A5A);
    push_op(bal_pkg::ACT_CLEAR, 63, 1'b1, 32'hFFFF_FFFF);
    push_op(bal_pkg::ACT_GET, 0, 1'b0, 32'h0);
    push_op(bal_pkg::ACT_REMOVE, 0, 1'b1, 32'h0);
    push_op(bal_pkg::ACT_ADD, 0, 1'b1, 32'h1234_5678);
    settle();

    run_phase(7'd127, 150, 78, 5, 17, 1'b1, 1'b0);
    run_phase(7'd127, 60, 35, 30, 33, 1'b1, 1'b1);
    run_phase(7'd4, 40, 20, 50, 25, 1'b1, 1'b0);
    run_phase(7'd0, 20, 40, 30, 25, 1'b1, 1'b0);
    run_phase(7'd1, 40, 40, 30, 25, 1'b1, 1'b0);
    run_phase(7'd2, 40, 40, 30, 25, 1'b1, 1'b0);
    mid_cap = 7'($urandom_range(3, 63));
    run_phase(mid_cap, 80, 65, 10, 23, 1'b1, 1'b0);
    run_phase(mid_cap, 60, 20, 55, 23, 1'b1, 1'b0);
    run_phase(7'd64, 65, 35, 30, 33, 1'b0, 1'b0);
    run_phase(7'd64, 65, 35, 30, 33, 1'b1, 1'b0);

    $display("covered %0d list requests across %0d capacity writes, 0 and 127 included",
             req_cnt, cap_writes);
    $display("results: ok %0d, invalid %0d, full %0d, empty %0d",
             status_seen[bal_pkg::ST_OK], status_seen[bal_pkg::ST_INVALID],
             status_seen[bal_pkg::ST_FULL], status_seen[bal_pkg::ST_EMPTY]);
    if (mism_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
